>>> hdl/u8sv_pkg.sv
// Package: item types and byte-class constants for the UTF-8 stream validator.
`default_nettype none

package u8sv_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       no_byte;
		logic       end_of_string;
	} item_t;

	typedef struct packed {
		logic valid_so_far;
		logic verdict_final;
	} result_t;

	localparam logic [7:0] BIT_7     = 8'h80;
	localparam logic [7:0] BIT_6     = 8'h40;
	localparam logic [7:0] BIT_5     = 8'h20;
	localparam logic [7:0] BIT_4     = 8'h10;
	localparam logic [7:0] BIT_3     = 8'h08;
	localparam logic [7:0] CONT_MASK = 8'hc0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] CTRL_LIM  = 8'h20;
	localparam logic [7:0] DEL_BYTE  = 8'h7f;

	localparam logic [1:0] OWE_NONE  = 2'd0;
	localparam logic [1:0] OWE_ONE   = 2'd1;
	localparam logic [1:0] OWE_TWO   = 2'd2;
	localparam logic [1:0] OWE_THREE = 2'd3;

endpackage

`default_nettype wire

>>> hdl/utf8_stream_validator.sv
// Top level: UTF-8 structure checker, one byte per item, one result per item.
//
// Takes one byte of a string per item and returns one result per item, one item per cycle
// sustained while byte_stall is low. The item is captured in an input register, decoded
// against the sequence state, and the result is registered at the output. byte_stall rises
// only when both registers are full and verdict_stall is high. The state (continuation
// bytes owed, error seen) is updated as the item moves into the output register. The final
// item of a string carries the verdict and clears the state.
`default_nettype none

module utf8_stream_validator
	import u8sv_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  wire     byte_valid,
	output logic    byte_stall,
	input  item_t   byte_item,
	output logic    verdict_valid,
	input  wire     verdict_stall,
	output result_t verdict_item
);

	item_t      item_s1;
	logic       valid_s1;
	result_t    res_s2;
	logic       valid_s2;
	logic [1:0] bytes_expected_q;
	logic       error_seen_q;

	logic       load_s2;
	logic       load_s1;
	logic [1:0] owe_n;
	logic       err_n;
	logic       ok;
	logic [7:0] b;

	assign load_s2    = valid_s1 && (!valid_s2 || !verdict_stall);
	assign byte_stall = valid_s1 && valid_s2 && verdict_stall;
	assign load_s1    = byte_valid && !byte_stall;
	assign b          = item_s1.data_byte;

	always_comb begin
		owe_n = bytes_expected_q;
		err_n = error_seen_q;
		if (!item_s1.no_byte) begin
			if (bytes_expected_q != OWE_NONE) begin
				if ((b & CONT_MASK) != CONT_TAG) begin
					err_n = 1'b1;
				end
				owe_n = bytes_expected_q - OWE_ONE;
			end else if ((b & BIT_7) == '0) begin
				if (b < CTRL_LIM || b == DEL_BYTE) begin
					err_n = 1'b1;
				end
			end else if ((b & BIT_6) == '0) begin
				err_n = 1'b1;
			end else if ((b & BIT_5) == '0) begin
				owe_n = OWE_ONE;
			end else if ((b & BIT_4) == '0) begin
				owe_n = OWE_TWO;
			end else if ((b & BIT_3) == '0) begin
				owe_n = OWE_THREE;
			end else begin
				err_n = 1'b1;
			end
		end
		ok = !err_n;
		if (item_s1.end_of_string) begin
			if (owe_n != OWE_NONE) begin
				ok = 1'b0;
			end
			owe_n = OWE_NONE;
			err_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			bytes_expected_q <= OWE_NONE;
			error_seen_q     <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2         <= 1'b1;
				bytes_expected_q <= owe_n;
				error_seen_q     <= err_n;
			end else if (!verdict_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= byte_item;
		end
		if (load_s2) begin
			res_s2.valid_so_far  <= ok;
			res_s2.verdict_final <= item_s1.end_of_string;
		end
	end

	assign verdict_valid = valid_s2;
	assign verdict_item  = res_s2;

endmodule

`default_nettype wire

>>> hdl/u8sv_checker.sv
// Checker: port-level assertions for the UTF-8 stream validator, bound to the top level.
`default_nettype none

module u8sv_checker
	import u8sv_pkg::*;
(
	input wire     clk,
	input wire     arst_n,
	input wire     byte_valid,
	input wire     byte_stall,
	input item_t   byte_item,
	input wire     verdict_valid,
	input wire     verdict_stall,
	input result_t verdict_item
);

	// input side stalls only behind a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (verdict_valid && verdict_stall))
		else $error("byte_stall without stalled verdict");

	// a fresh result follows an accepted item through the input and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(verdict_valid) |-> $past(byte_valid && !byte_stall, 2))
		else $error("verdict without a matching item");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(verdict_valid && verdict_stall) |=> (verdict_valid && $stable(verdict_item)))
		else $error("stalled verdict changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && byte_stall) |=> (byte_valid && $stable(byte_item)))
		else $error("stalled item changed");

endmodule

bind utf8_stream_validator u8sv_checker u_u8sv_checker (.*);

`default_nettype wire

>>> tb/sv/utf8_stream_validator_test.sv
// Testbench for the UTF-8 stream validator: directed table, random strings, scoreboard check.
module utf8_stream_validator_test
	import u8sv_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data_b;
		logic       none;
		logic       last;
		logic       typed;
		logic       want_ok;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    byte_valid = 1'b0;
	logic    byte_stall;
	item_t   byte_item = '0;
	logic    verdict_valid;
	logic    verdict_stall = 1'b0;
	result_t verdict_item;

	logic [1:0] owed_cont = OWE_NONE;
	logic       seen_bad = 1'b0;
	result_t    verdict_q[$];
	int         sent_cnt = 0;
	int         fail_cnt = 0;
	bit         quiet = 1'b0;
	bit         hold_req = 1'b0;

	// typed rows: after reset, field extremes, truncation; the others go to the predictor
	row_t dir_rows [0:24] = '{
		{8'hA5, 1'b1, 1'b1, 1'b1, 1'b1},
		{8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
		{8'h1F, 1'b0, 1'b1, 1'b1, 1'b0},
		{8'h20, 1'b0, 1'b1, 1'b1, 1'b1},
		{8'h7E, 1'b0, 1'b1, 1'b1, 1'b1},
		{8'h7F, 1'b0, 1'b1, 1'b1, 1'b0},
		{8'h80, 1'b0, 1'b1, 1'b1, 1'b0},
		{8'hF8, 1'b0, 1'b1, 1'b1, 1'b0},
		{8'hFF, 1'b0, 1'b1, 1'b1, 1'b0},
		{8'hC3, 1'b0, 1'b0, 1'b0, 1'b0},
		{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0},
		{8'hA9, 1'b0, 1'b1, 1'b0, 1'b0},
		{8'hE2, 1'b0, 1'b0, 1'b0, 1'b0},
		{8'h82, 1'b0, 1'b0, 1'b0, 1'b0},
		{8'hAC, 1'b0, 1'b1, 1'b0, 1'b0},
		{8'hF0, 1'b0, 1'b0, 1'b0, 1'b0},
		{8'h9F, 1'b0, 1'b0, 1'b0, 1'b0},
		{8'h98, 1'b0, 1'b0, 1'b0, 1'b0},
		{8'h80, 1'b0, 1'b1, 1'b0, 1'b0},
		{8'hE2, 1'b0, 1'b1, 1'b1, 1'b0},
		{8'hC3, 1'b0, 1'b0, 1'b0, 1'b0},
		{8'h00, 1'b1, 1'b1, 1'b0, 1'b0},
		{8'hC3, 1'b0, 1'b0, 1'b0, 1'b0},
		{8'h41, 1'b0, 1'b0, 1'b0, 1'b0},
		{8'h41, 1'b0, 1'b1, 1'b0, 1'b0}
	};

	utf8_stream_validator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.byte_item     (byte_item),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.verdict_item  (verdict_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic item_t mk_item(logic [7:0] b, logic nb, logic eos);
		item_t it;
		it.data_byte = b;
		it.no_byte = nb;
		it.end_of_string = eos;
		return it;
	endfunction

	function automatic result_t next_verdict(item_t it);
		result_t    r;
		logic [7:0] b;
		b = it.data_byte;
		if (!it.no_byte) begin
			if (owed_cont != OWE_NONE) begin
				if ((b & CONT_MASK) != CONT_TAG)
					seen_bad = 1'b1;
				owed_cont = owed_cont - 2'd1;
			end else if ((b & BIT_7) == 8'h00) begin
				if (b < CTRL_LIM || b == DEL_BYTE)
					seen_bad = 1'b1;
			end else if ((b & BIT_6) == 8'h00) begin
				seen_bad = 1'b1;
			end else if ((b & BIT_5) == 8'h00) begin
				owed_cont = OWE_ONE;
			end else if ((b & BIT_4) == 8'h00) begin
				owed_cont = OWE_TWO;
			end else if ((b & BIT_3) == 8'h00) begin
				owed_cont = OWE_THREE;
			end else begin
				seen_bad = 1'b1;
			end
		end
		r.valid_so_far = !seen_bad;
		r.verdict_final = it.end_of_string;
		if (it.end_of_string) begin
			if (owed_cont != OWE_NONE)
				r.valid_so_far = 1'b0;
			owed_cont = OWE_NONE;
			seen_bad = 1'b0;
		end
		return r;
	endfunction

	task automatic report(string what, int want, int got);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("mismatch %s: expected %0d, got %0d", what, want, got);
	endtask

	task automatic send_item(item_t it, bit typed, logic want_ok);
		result_t pred;
		if (!quiet && $urandom_range(9, 0) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		@(posedge clk);
		while (byte_stall !== 1'b0)
			@(posedge clk);
		pred = next_verdict(it);
		if (typed)
			pred.valid_so_far = want_ok;
		verdict_q.push_back(pred);
		sent_cnt++;
	endtask

	task automatic pause_until_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	// mostly well-formed strings; some noise, broken sequences and byte-less items
	task automatic send_random_string();
		item_t str[$];
		int    mode;
		int    n_chars;
		int    len;
		mode = $urandom_range(9, 0);
		n_chars = $urandom_range(8, 0);
		for (int c = 0; c < n_chars; c++) begin
			if (mode == 7) begin
				str.push_back(mk_item(8'($urandom_range(255, 0)), 1'b0, 1'b0));
			end else begin
				len = $urandom_range(3, 0);
				case (len)
					0: str.push_back(mk_item(8'($urandom_range(8'h7E, 8'h20)), 1'b0, 1'b0));
					1: str.push_back(mk_item(8'hC0 | 8'($urandom_range(31, 0)), 1'b0, 1'b0));
					2: str.push_back(mk_item(8'hE0 | 8'($urandom_range(15, 0)), 1'b0, 1'b0));
					default: str.push_back(mk_item(8'hF0 | 8'($urandom_range(7, 0)), 1'b0, 1'b0));
				endcase
				for (int k = 0; k < len; k++)
					str.push_back(mk_item(8'h80 | 8'($urandom_range(63, 0)), 1'b0, 1'b0));
			end
		end
		if (mode == 8 && str.size() > 0) begin
			if ($urandom_range(1, 0) == 0)
				void'(str.pop_back());
			else
				str[$urandom_range(str.size() - 1, 0)] =
					mk_item(8'($urandom_range(255, 0)), 1'b0, 1'b0);
		end
		if (mode == 9) begin
			repeat ($urandom_range(3, 1))
				str.insert($urandom_range(str.size(), 0),
					mk_item(8'($urandom_range(255, 0)), 1'b1, 1'b0));
		end
		if (str.size() == 0 || $urandom_range(15, 0) == 0)
			str.push_back(mk_item(8'($urandom_range(255, 0)), 1'b1, 1'b0));
		str[str.size() - 1].end_of_string = 1'b1;
		foreach (str[i])
			send_item(str[i], 1'b0, 1'b0);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && verdict_valid && !verdict_stall) begin
			if (verdict_q.size() == 0) begin
				report("result with nothing pending", 0, 1);
			end else begin
				want = verdict_q.pop_front();
				if (verdict_item.valid_so_far !== want.valid_so_far)
					report("valid_so_far", want.valid_so_far, verdict_item.valid_so_far);
				if (verdict_item.verdict_final !== want.verdict_final)
					report("verdict_final", want.verdict_final, verdict_item.verdict_final);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				verdict_stall <= 1'b1;
				repeat (60) @(posedge clk);
				verdict_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(9, 0) == 0) begin
				verdict_stall <= 1'b1;
				repeat ($urandom_range(8, 1)) @(posedge clk);
				verdict_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		bit hold_done;
		bit drain_done;
		int waited;
		hold_done = 1'b0;
		drain_done = 1'b0;
		waited = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_item(mk_item(dir_rows[i].data_b, dir_rows[i].none, dir_rows[i].last),
				dir_rows[i].typed, dir_rows[i].want_ok);
		pause_until_drained();
		while (sent_cnt < 925) begin
			if (!hold_done && sent_cnt >= 300) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!drain_done && sent_cnt >= 600) begin
				pause_until_drained();
				drain_done = 1'b1;
			end
			quiet = (sent_cnt >= 780);
			send_random_string();
		end
		byte_valid <= 1'b0;
		while (verdict_q.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (verdict_q.size() != 0)
			report("results still pending", 0, verdict_q.size());
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
